>>> design/tmn_pkg.sv
package tmn_pkg;

   localparam int ID_W = 5;
   localparam int OP_W = 2;
   localparam int ACT_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int QUEUE_DEPTH_DEF = 8;

   // register indexes, taken from paddr[2]
   localparam logic CSR_SELF_ID = 1'b0;
   localparam logic CSR_INIT_HOLDER = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_PRIV  = 2'd0,
      OP_REQ   = 2'd1,
      OP_TICK  = 2'd2,
      OP_DRAIN = 2'd3
   } op_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_CS   = 2'd0,
      ACT_PRIV = 2'd1,
      ACT_REQ  = 2'd2,
      ACT_OVF  = 2'd3
   } act_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_PUSH,
      ST_FRONT_RD,
      ST_FRONT,
      ST_ASK
   } state_type;

   typedef struct packed {
      logic push;
      logic pop;
   } q_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

>>> design/tmn_queue.sv
module tmn_queue #(
   parameter int DEPTH = tmn_pkg::QUEUE_DEPTH_DEF,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tmn_pkg::q_ctl_type       ctl,
   input  logic [tmn_pkg::ID_W-1:0] push_data,
   input  logic [PTR_W-1:0]         rd_off,
   output logic [tmn_pkg::ID_W-1:0] rd_data,
   output logic [CNT_W-1:0]         count,
   output tmn_pkg::q_stat_type      stat
);
   import tmn_pkg::*;

   localparam logic [PTR_W:0] DEPTH_P = (PTR_W + 1)'(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   logic [ID_W-1:0]  mem_ff [DEPTH];
   logic [ID_W-1:0]  rd_data_ff;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] tail;
   logic [PTR_W-1:0] rd_addr;
   logic             do_push;

   // circular add, both operands below DEPTH
   function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] a,
                                                input logic [PTR_W-1:0] b);
      logic [PTR_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= DEPTH_P) begin
         sum = sum - DEPTH_P;
      end
      return sum[PTR_W-1:0];
   endfunction

   assign stat.full  = (count_ff == DEPTH_C);
   assign stat.empty = (count_ff == '0);
   assign count      = count_ff;
   assign rd_data    = rd_data_ff;
   assign do_push    = ctl.push && !stat.full;
   assign tail       = ptr_add(head_ff, count_ff[PTR_W-1:0]);
   assign rd_addr    = ptr_add(head_ff, rd_off);

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (do_push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pop && !stat.empty) begin
         head_in  = ptr_add(head_ff, PTR_W'(1));
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[tail] <= push_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("queue count beyond depth");

   a_full_push_drops: assert property (@(posedge clock) disable iff (reset)
      ctl.push && stat.full |=> $stable(count_ff))
      else $error("push into full queue changed count");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |-> !stat.empty && !ctl.push)
      else $error("pop from empty queue or with push");
`endif

endmodule

>>> design/tree_token_mutex_node.sv
// one node of a token tree mutual exclusion scheme
// command channel: an event (req_op, req_requester_id) is taken at a clock edge
// where start is high and busy is low
// result channel: each result sits on rsp_action, rsp_dest_id, rsp_last for one
// cycle with rsp_valid high; rsp_last marks the final result of an event
// the receiver cannot stall, so results are never held back
// csr port (apb style, pready tied high): self_id at 0x0, initial_holder at 0x4;
// writing initial_holder also loads the holder pointer
// busy states per event:
//   privilege or request received: none (taken in the accept cycle, result, if
//   any, in the next cycle)
//   request tick: the one id comparator walks the queue entry by entry (memory
//   read, then compare), pushes own id if it is absent, then reads the queue
//   front; drain tick: reads the front, then ST_ASK when a privilege is passed
//   and a request follows
// results are registered and show in the cycle after they are decided; two
// results of one event come from ST_PUSH and ST_FRONT, or ST_FRONT and ST_ASK
// reset: holder = 1, self = 1, asked clear, queue empty, no clearing pass
module tree_token_mutex_node #(
   parameter int QUEUE_DEPTH = tmn_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [tmn_pkg::OP_W-1:0]       req_op,
   input  logic [tmn_pkg::ID_W-1:0]       req_requester_id,
   output logic                           rsp_valid,
   output logic [tmn_pkg::ACT_W-1:0]      rsp_action,
   output logic [tmn_pkg::ID_W-1:0]       rsp_dest_id,
   output logic                           rsp_last,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [tmn_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [tmn_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [tmn_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import tmn_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [ID_W-1:0]  self_id_ff, self_id_in;
   logic [ID_W-1:0]  init_holder_ff, init_holder_in;
   logic [ID_W-1:0]  holder_ff, holder_in;
   logic             asked_ff, asked_in;
   logic             rsp_valid_ff, rsp_valid_in;
   act_type          rsp_action_ff, rsp_action_in;
   logic [ID_W-1:0]  rsp_dest_ff, rsp_dest_in;
   logic             rsp_last_ff, rsp_last_in;

   q_ctl_type        q_ctl;
   q_stat_type       q_stat;
   logic [ID_W-1:0]  q_push_data;
   logic [PTR_W-1:0] q_rd_off;
   logic [ID_W-1:0]  q_rd_data;
   logic [CNT_W-1:0] q_count;

   logic             csr_wr;
   logic             csr_idx;
   logic             holds;
   logic             accept;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[2];
   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign holds   = (holder_ff == self_id_ff);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_action  = rsp_action_ff;
   assign rsp_dest_id = rsp_dest_ff;
   assign rsp_last    = rsp_last_ff;

   assign q_push_data = (state_ff == ST_IDLE) ? req_requester_id : self_id_ff;
   assign q_rd_off    = (state_ff == ST_SCAN_RD) ? scan_ff[PTR_W-1:0] : '0;

   always_comb begin
      case (csr_idx)
         CSR_SELF_ID:     prdata = CSR_DATA_W'(self_id_ff);
         CSR_INIT_HOLDER: prdata = CSR_DATA_W'(init_holder_ff);
         default:         prdata = '0;
      endcase
   end

   tmn_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctl       (q_ctl),
      .push_data (q_push_data),
      .rd_off    (q_rd_off),
      .rd_data   (q_rd_data),
      .count     (q_count),
      .stat      (q_stat)
   );

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      scan_in        = scan_ff;
      holder_in      = holder_ff;
      asked_in       = asked_ff;
      self_id_in     = self_id_ff;
      init_holder_in = init_holder_ff;
      q_ctl          = '0;
      rsp_valid_in   = 1'b0;
      rsp_action_in  = rsp_action_ff;
      rsp_dest_in    = rsp_dest_ff;
      rsp_last_in    = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in = op_type'(req_op);
               case (op_type'(req_op))
                  OP_PRIV: holder_in = self_id_ff;
                  OP_REQ: begin
                     q_ctl.push = 1'b1;
                     if (q_stat.full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_action_in = ACT_OVF;
                        rsp_dest_in   = '0;
                        rsp_last_in   = 1'b1;
                     end
                  end
                  OP_TICK: begin
                     scan_in  = '0;
                     state_in = ST_SCAN_RD;
                  end
                  OP_DRAIN: state_in = ST_FRONT_RD;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN_RD: begin
            // end of the queue means own id is absent
            state_in = (scan_ff == q_count) ? ST_PUSH : ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (q_rd_data == self_id_ff) begin
               state_in = ST_FRONT_RD;
            end else begin
               scan_in  = scan_ff + CNT_W'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_PUSH: begin
            q_ctl.push = 1'b1;
            if (q_stat.full) begin
               // a later result follows unless no request can go out
               rsp_valid_in  = 1'b1;
               rsp_action_in = ACT_OVF;
               rsp_dest_in   = '0;
               rsp_last_in   = !holds && asked_ff;
            end
            state_in = ST_FRONT_RD;
         end
         ST_FRONT_RD: state_in = ST_FRONT;
         ST_FRONT: begin
            state_in = ST_IDLE;
            if (op_ff == OP_TICK) begin
               if (holds && !q_stat.empty && q_rd_data == self_id_ff) begin
                  q_ctl.pop     = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_action_in = ACT_CS;
                  rsp_dest_in   = '0;
                  rsp_last_in   = 1'b1;
               end else if (holds && !q_stat.empty) begin
                  q_ctl.pop     = 1'b1;
                  asked_in      = 1'b0;
                  holder_in     = q_rd_data;
                  rsp_valid_in  = 1'b1;
                  rsp_action_in = ACT_PRIV;
                  rsp_dest_in   = q_rd_data;
                  rsp_last_in   = 1'b1;
               end else if (!q_stat.empty && !asked_ff && !holds) begin
                  asked_in      = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_action_in = ACT_REQ;
                  rsp_dest_in   = holder_ff;
                  rsp_last_in   = 1'b1;
               end
            end else begin
               if (holds && !q_stat.empty && q_rd_data != self_id_ff) begin
                  // new holder is a neighbor, so a request follows if more wait
                  q_ctl.pop     = 1'b1;
                  asked_in      = 1'b0;
                  holder_in     = q_rd_data;
                  rsp_valid_in  = 1'b1;
                  rsp_action_in = ACT_PRIV;
                  rsp_dest_in   = q_rd_data;
                  rsp_last_in   = (q_count == CNT_W'(1));
                  state_in      = (q_count == CNT_W'(1)) ? ST_IDLE : ST_ASK;
               end else if (!q_stat.empty && !asked_ff && !holds) begin
                  asked_in      = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_action_in = ACT_REQ;
                  rsp_dest_in   = holder_ff;
                  rsp_last_in   = 1'b1;
               end
            end
         end
         ST_ASK: begin
            asked_in      = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_action_in = ACT_REQ;
            rsp_dest_in   = holder_ff;
            rsp_last_in   = 1'b1;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_wr) begin
         case (csr_idx)
            CSR_SELF_ID: self_id_in = pwdata[ID_W-1:0];
            CSR_INIT_HOLDER: begin
               init_holder_in = pwdata[ID_W-1:0];
               holder_in      = pwdata[ID_W-1:0];
            end
            default: self_id_in = self_id_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         self_id_ff     <= ID_W'(1);
         init_holder_ff <= ID_W'(1);
         holder_ff      <= ID_W'(1);
         asked_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         self_id_ff     <= self_id_in;
         init_holder_ff <= init_holder_in;
         holder_ff      <= holder_in;
         asked_ff       <= asked_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      scan_ff       <= scan_in;
      rsp_action_ff <= rsp_action_in;
      rsp_dest_ff   <= rsp_dest_in;
      rsp_last_ff   <= rsp_last_in;
   end

`ifndef SYNTHESIS
   a_more_beats_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> busy)
      else $error("non-final result beat with sequencer idle");

   a_tick_goes_busy: assert property (@(posedge clock) disable iff (reset)
      accept && (req_op == OP_TICK || req_op == OP_DRAIN) |=> busy)
      else $error("tick accepted but sequencer stayed idle");

   a_asked_with_request: assert property (@(posedge clock) disable iff (reset)
      $rose(asked_ff) |-> rsp_valid_ff && rsp_action_ff == ACT_REQ)
      else $error("asked flag set without a request beat");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN_CMP |-> scan_ff < q_count)
      else $error("queue scan past the fill count");
`endif

endmodule
